// ===== src/mbq_pkg.sv =====
// Package for the multichannel biquad filter: widths, reset coefficients,
// register indexes and the structs passed between the top level and the datapath.
// No dependencies.
package mbq_pkg;

  // Channel count of the history store; the channel field itself is fixed at 3 bits.
  localparam int CHANNELS = 8;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int CH_W     = 3;
  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 32;
  localparam int Y_W      = 48;

  // Reset coefficients, Q2.30, with the 1e-3 gain folded into the b terms.
  localparam logic signed [COEF_W-1:0] B0_RST = 32'sd235472;
  localparam logic signed [COEF_W-1:0] B1_RST = 32'sd470836;
  localparam logic signed [COEF_W-1:0] B2_RST = 32'sd235472;
  localparam logic signed [COEF_W-1:0] A1_RST = -32'sd2092185944;
  localparam logic signed [COEF_W-1:0] A2_RST = 32'sd1019410488;

  typedef enum logic [2:0] {
    REG_COEF_B0 = 3'd0,
    REG_COEF_B1 = 3'd1,
    REG_COEF_B2 = 3'd2,
    REG_COEF_A1 = 3'd3,
    REG_COEF_A2 = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [Y_W-1:0]      y1;
    logic signed [Y_W-1:0]      y2;
  } hist_t;

endpackage

// ===== src/multichannel_biquad_filter_top.sv =====
// Top level of the multichannel biquad filter: handshake pipeline, coefficient
// registers and per-channel history. Depends on mbq_pkg and mbq_datapath.
//
// One sample enters per clock while in_stall is low. Its result passes through the
// input register, then the result register, and is held there while out_stall is
// high. One transaction completes per cycle while out_stall is low, including
// consecutive samples of the same channel, because the history for a channel
// is updated at the same edge that loads the result register. The critical
// path is the combinational datapath of seven 32x24 multiplies and their sum.
// A channel number not below the channel count passes through with a zero
// sample and leaves all history untouched.
// Coefficients are Q2.30 and may be rewritten only while the filter is idle.
module multichannel_biquad_filter_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mbq_pkg::CH_W-1:0]             in_channel,
  input  logic signed [mbq_pkg::SAMPLE_W-1:0]  in_sample_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mbq_pkg::CH_W-1:0]             out_channel_out,
  output logic signed [mbq_pkg::SAMPLE_W-1:0]  out_sample_out,
  input  logic                                 cfg_wr_en,
  input  logic [2:0]                           cfg_index,
  input  logic [mbq_pkg::COEF_W-1:0]           cfg_wdata
);

  mbq_pkg::coef_t coef_r;

  logic signed [mbq_pkg::SAMPLE_W-1:0] x1_r [mbq_pkg::CHANNELS];
  logic signed [mbq_pkg::SAMPLE_W-1:0] x2_r [mbq_pkg::CHANNELS];
  logic signed [mbq_pkg::Y_W-1:0]      y1_r [mbq_pkg::CHANNELS];
  logic signed [mbq_pkg::Y_W-1:0]      y2_r [mbq_pkg::CHANNELS];

  logic                                s1_valid_r;
  logic [mbq_pkg::CH_W-1:0]            s1_ch_r;
  logic signed [mbq_pkg::SAMPLE_W-1:0] s1_x_r;

  logic                                out_valid_r;
  logic [mbq_pkg::CH_W-1:0]            out_ch_r;
  logic signed [mbq_pkg::SAMPLE_W-1:0] out_sample_r;
  logic signed [mbq_pkg::SAMPLE_W-1:0] out_sample_nxt;

  logic                                advance;
  logic                                in_take;
  logic                                ch_ok;
  logic [mbq_pkg::CH_IDX_W-1:0]        idx;
  mbq_pkg::hist_t                      hist;
  logic signed [mbq_pkg::Y_W-1:0]      dp_y;
  logic signed [mbq_pkg::SAMPLE_W-1:0] dp_sample;

  // The result register frees up when empty or when its transaction completes.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign idx   = s1_ch_r[mbq_pkg::CH_IDX_W-1:0];
  assign ch_ok = 32'(s1_ch_r) < mbq_pkg::CHANNELS;

  always_comb begin
    hist.x1 = x1_r[idx];
    hist.x2 = x2_r[idx];
    hist.y1 = y1_r[idx];
    hist.y2 = y2_r[idx];
    out_sample_nxt = ch_ok ? dp_sample : '0;
  end

  mbq_datapath u_datapath (
    .coef   (coef_r),
    .hist   (hist),
    .x      (s1_x_r),
    .y_new  (dp_y),
    .sample (dp_sample)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.b0 <= mbq_pkg::B0_RST;
      coef_r.b1 <= mbq_pkg::B1_RST;
      coef_r.b2 <= mbq_pkg::B2_RST;
      coef_r.a1 <= mbq_pkg::A1_RST;
      coef_r.a2 <= mbq_pkg::A2_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mbq_pkg::REG_COEF_B0: coef_r.b0 <= cfg_wdata;
        mbq_pkg::REG_COEF_B1: coef_r.b1 <= cfg_wdata;
        mbq_pkg::REG_COEF_B2: coef_r.b2 <= cfg_wdata;
        mbq_pkg::REG_COEF_A1: coef_r.a1 <= cfg_wdata;
        mbq_pkg::REG_COEF_A2: coef_r.a2 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mbq_pkg::CHANNELS; i++) begin
        x1_r[i] <= '0;
        x2_r[i] <= '0;
        y1_r[i] <= '0;
        y2_r[i] <= '0;
      end
    end else if (s1_valid_r && advance && ch_ok) begin
      x2_r[idx] <= x1_r[idx];
      x1_r[idx] <= s1_x_r;
      y2_r[idx] <= y1_r[idx];
      y1_r[idx] <= dp_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ch_r <= in_channel;
      s1_x_r  <= in_sample_in;
    end
    if (s1_valid_r && advance) begin
      out_ch_r     <= s1_ch_r;
      out_sample_r <= out_sample_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel_out = out_ch_r;
  assign out_sample_out  = out_sample_r;

endmodule

// ===== src/mbq_datapath.sv =====
// Biquad arithmetic for one sample: five coefficient products, accumulation,
// rounding and saturation of the Q24.24 history value and of the output sample.
// Depends on mbq_pkg.
module mbq_datapath (
  input  mbq_pkg::coef_t                       coef,
  input  mbq_pkg::hist_t                       hist,
  input  logic signed [mbq_pkg::SAMPLE_W-1:0]  x,
  output logic signed [mbq_pkg::Y_W-1:0]       y_new,
  output logic signed [mbq_pkg::SAMPLE_W-1:0]  sample
);

  // floor(a * y / 2^24) in units of 2^-30, with y split into an integer part
  // and an unsigned 24-bit fraction so that each product stays 32 by 24 bits.
  function automatic logic signed [56:0] feedback_term(
    input logic signed [31:0] a,
    input logic signed [47:0] y
  );
    logic signed [23:0] hi;
    logic signed [24:0] lo;
    logic signed [55:0] ph;
    logic signed [56:0] pl;
    hi = y[47:24];
    lo = {1'b0, y[23:0]};
    ph = a * hi;
    pl = a * lo;
    return 57'(ph) + (pl >>> 24);
  endfunction

  logic signed [31:0] b0, b1, b2, a1, a2;
  logic signed [23:0] x1, x2;
  logic signed [47:0] y1, y2;
  logic signed [55:0] pb0, pb1, pb2;
  logic signed [56:0] fb1, fb2;
  logic signed [59:0] acc;
  logic signed [59:0] acc_rnd;
  logic signed [59:0] yq;
  logic signed [48:0] s_rnd;
  logic signed [24:0] s_full;

  always_comb begin
    b0 = coef.b0;
    b1 = coef.b1;
    b2 = coef.b2;
    a1 = coef.a1;
    a2 = coef.a2;
    x1 = hist.x1;
    x2 = hist.x2;
    y1 = hist.y1;
    y2 = hist.y2;

    pb0 = b0 * x;
    pb1 = b1 * x1;
    pb2 = b2 * x2;
    fb1 = feedback_term(a1, y1);
    fb2 = feedback_term(a2, y2);

    acc = 60'(pb0) + 60'(pb1) + 60'(pb2) - 60'(fb1) - 60'(fb2);

    // Round to units of 2^-24, then clamp to the signed 48-bit history range.
    acc_rnd = acc + 60'sd32;
    yq      = acc_rnd >>> 6;
    if (yq[59:47] == '0 || yq[59:47] == '1) begin
      y_new = yq[47:0];
    end else if (yq[59]) begin
      y_new = {1'b1, 47'd0};
    end else begin
      y_new = {1'b0, {47{1'b1}}};
    end

    // Round to an integer and clamp to 24 bits.
    s_rnd  = 49'(y_new) + 49'sd8388608;
    s_full = s_rnd[48:24];
    if (s_full[24] == s_full[23]) begin
      sample = s_full[23:0];
    end else if (s_full[24]) begin
      sample = {1'b1, 23'd0};
    end else begin
      sample = {1'b0, {23{1'b1}}};
    end
  end

endmodule
